/* src/rmd_pkg.sv */
// Shared widths and constants for the running mean difference unit.
`default_nettype none

package rmd_pkg;

  localparam int unsigned Window  = 16;
  localparam int unsigned SampleW = 24;
  localparam int unsigned OutW    = SampleW + 1;
  localparam int unsigned PosW    = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW    = $clog2(Window + 1);
  localparam int unsigned SumW    = SampleW + $clog2(Window);
  localparam int unsigned StepW   = $clog2(SumW + 1);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [OutW-1:0]    diff_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic [PosW-1:0]           pos_t;
  typedef logic [CntW-1:0]           cnt_t;

  // Ring write and read port controls.
  typedef struct packed {
    logic    we;
    pos_t    waddr;
    sample_t wdata;
    logic    re;
    pos_t    raddr;
  } ring_ctrl_t;

endpackage

`default_nettype wire

/* src/rmd_ring.sv */
// Sample ring memory with one write port and one registered read port.
`default_nettype none

module rmd_ring
  import rmd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire ring_ctrl_t ctrl_i,
  output sample_t         rdata_o
);

  sample_t mem_q [Window];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[ctrl_i.waddr] <= ctrl_i.wdata;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem_q[ctrl_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/rmd_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module rmd_div
  import rmd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] dividend_i,
  input  wire cnt_t            divisor_i,
  output logic                 done_o,
  output logic [SumW-1:0]      quotient_o
);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e        state_q;
  logic [StepW-1:0]  step_q;
  logic [SumW-1:0]   quo_q;
  cnt_t              rem_q;
  cnt_t              dsr_q;
  logic              done_q;
  logic [CntW:0]     trial;
  logic              fits;
  cnt_t              rem_d;

  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? CntW'(trial - {1'b0, dsr_q}) : trial[CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DIV_IDLE: begin
          if (start_i) begin
            quo_q   <= dividend_i;
            dsr_q   <= divisor_i;
            rem_q   <= '0;
            step_q  <= StepW'(SumW);
            state_q <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          rem_q  <= rem_d;
          quo_q  <= {quo_q[SumW-2:0], fits};
          step_q <= step_q - 1'b1;
          if (step_q == StepW'(1)) begin
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* src/running_mean_difference_unit.sv */
// Top level of the running mean difference unit with its sequencer.
//
// Each input beat carries one signed Q15.8 sample on sample_i. The unit keeps
// a ring of the last 16 samples and their running sum, divides the sum by the
// number of samples held so far (rounded to nearest, ties away from zero) and
// returns the sample minus that average as a signed Q16.8 output beat.
// Both channels use valid and ready handshakes. One input beat produces
// exactly one output beat. After acceptance, ST_UPDATE updates the sum and the
// ring, ST_PREP forms the rounded magnitude and starts the divider, the
// bit-serial divider runs one step per sum bit, ST_DIV hands the quotient back
// to the sequencer and ST_OUT loads the output register. in_ready_o is high
// only while the sequencer is idle, so the unit takes no new sample until the
// last one has been loaded into the output register.
// The output register holds a finished beat while the receiver stalls, and
// a new sample is still accepted then; that sample completes its division
// and waits until the held beat is taken. Reset empties the window: the sum,
// write position and fill count go to zero, and early outputs average only
// the samples seen so far.
`default_nettype none

module running_mean_difference_unit
  import rmd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire sample_t sample_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output diff_t        mean_difference_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e          state_q;
  sample_t         sample_q;
  sum_t            sum_q;
  pos_t            pos_q;
  cnt_t            fill_q;
  logic            neg_q;
  logic            out_valid_q;
  diff_t           out_q;

  ring_ctrl_t      ring_ctrl;
  sample_t         ring_rdata;
  sample_t         old_sample;
  sum_t            sum_d;
  logic [SumW-1:0] sum_mag;
  logic [SumW-1:0] dividend;
  logic            div_done;
  logic [SumW-1:0] quotient;
  diff_t           diff_d;
  logic            full;
  logic            accept;
  logic            out_free;

  assign full     = (fill_q == CntW'(Window));
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ring_ctrl.re    = accept;
    ring_ctrl.raddr = pos_q;
    ring_ctrl.we    = (state_q == ST_UPDATE);
    ring_ctrl.waddr = pos_q;
    ring_ctrl.wdata = sample_q;
  end

  rmd_ring u_ring (
    .clk_i   (clk_i),
    .ctrl_i  (ring_ctrl),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    old_sample = full ? ring_rdata : '0;
    sum_d      = sum_q - {{(SumW-SampleW){old_sample[SampleW-1]}}, old_sample}
                       + {{(SumW-SampleW){sample_q[SampleW-1]}}, sample_q};
    sum_mag    = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;
    dividend   = sum_mag + SumW'(fill_q >> 1);
  end

  rmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_PREP),
    .dividend_i (dividend),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (neg_q) begin
      diff_d = {sample_q[SampleW-1], sample_q} + diff_t'(quotient[OutW-1:0]);
    end else begin
      diff_d = {sample_q[SampleW-1], sample_q} - diff_t'(quotient[OutW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sample_q <= sample_i;
            state_q  <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum_q   <= sum_d;
          pos_q   <= (pos_q == PosW'(Window - 1)) ? '0 : pos_q + 1'b1;
          if (!full) begin
            fill_q <= fill_q + 1'b1;
          end
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          neg_q   <= sum_q[SumW-1];
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_q       <= diff_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign mean_difference_o = out_q;

endmodule

`default_nettype wire

/* test/running_mean_difference_unit_test.sv */
// Self-checking testbench for the running mean difference unit.
module running_mean_difference_unit_test
  import rmd_pkg::*;
();

  localparam sample_t SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam int      DrainCycles = 40;

  class mean_diff_scoreboard;
    sample_t     history[Window];
    longint      history_sum;
    int unsigned next_slot;
    int unsigned samples_held;
    diff_t       expected_diffs[$];
    int          errors;
    int          results_checked;

    function new();
      foreach (history[i]) history[i] = '0;
      history_sum     = 0;
      next_slot       = 0;
      samples_held    = 0;
      errors          = 0;
      results_checked = 0;
    endfunction

    function int pending();
      return expected_diffs.size();
    endfunction

    function void note_sample(sample_t s);
      longint magnitude;
      longint avg;
      longint diff;
      history_sum = history_sum - longint'(history[next_slot]) + longint'(s);
      history[next_slot] = s;
      next_slot = (next_slot + 1) % Window;
      if (samples_held < Window) samples_held++;
      magnitude = (history_sum < 0) ? -history_sum : history_sum;
      avg = (magnitude + longint'(samples_held / 2)) / longint'(samples_held);
      if (history_sum < 0) avg = -avg;
      diff = longint'(s) - avg;
      expected_diffs.push_back(diff_t'(diff));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(diff_t got);
      diff_t want;
      if (expected_diffs.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", got));
      end else begin
        want = expected_diffs.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("result %0d: mean_difference got %0d, expected %0d",
                                    results_checked, got, want));
        end
      end
      results_checked++;
    endtask
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  sample_t sample_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  diff_t   mean_difference_o;

  mean_diff_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int samples_sent = 0;

  running_mean_difference_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .mean_difference_o (mean_difference_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(mean_difference_o);
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task send_sample(sample_t s);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function sample_t random_sample();
    case ($urandom_range(7))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return sample_t'(int'($urandom_range(16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task run_phase(int n, int s_idle, int r_stall);
    int      k;
    sample_t extreme;
    sender_idle_pct    = s_idle;
    receiver_stall_pct = r_stall;
    k = 0;
    while (k < n) begin
      if ($urandom_range(39) == 0) begin
        extreme = $urandom_range(1) ? SampleMax : SampleMin;
        repeat (Window) send_sample(extreme);
        k += Window;
      end else begin
        send_sample(random_sample());
        k++;
      end
    end
    drain();
  endtask

  initial begin
    sample_t directed[$];
    directed = '{SampleMax, SampleMin, sample_t'(1), sample_t'(-1), sample_t'(0),
                 sample_t'(2), sample_t'(-5), sample_t'(7)};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Early samples exercise the partial window and the rounding ties, then a
    // full window of the most negative sample drives the sum to its limit.
    foreach (directed[i]) send_sample(directed[i]);
    repeat (Window) send_sample(SampleMin);
    drain();

    run_phase(410, 0, 0);
    run_phase(410, 47, 0);
    run_phase(410, 0, 47);
    run_phase(410, 21, 21);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d results over directed, back-to-back,",
             samples_sent, sb.results_checked);
    $display("sender-idle, receiver-stall and mixed phases; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
src/rmd_pkg.sv
src/rmd_ring.sv
src/rmd_div.sv
src/running_mean_difference_unit.sv
test/running_mean_difference_unit_test.sv
